// ===== sv/lsl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and register codes for the lidar sector speed limiter.
// No dependencies; every other file imports this package.
package lsl_pkg;

  localparam int POS_W      = 16;
  localparam int VEL_W      = 16;
  localparam int DIST_W     = 16;
  localparam int DSQ_W      = 32;
  localparam int SCALE_W    = 9;
  localparam int CNT_W      = 16;
  localparam int AGE_W      = 8;
  localparam int MODE_W     = 6;
  localparam int NUM_SECT   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = 32;

  // sector order
  localparam int SEC_FRONT = 0;
  localparam int SEC_BACK  = 1;
  localparam int SEC_LEFT  = 2;
  localparam int SEC_RIGHT = 3;

  // mode_flags bits
  localparam int MODE_ESTOP        = 0;
  localparam int MODE_EN_BASE      = 1;
  localparam int MODE_PASS_NOCLOUD = 5;

  localparam logic [AGE_W-1:0]   CMD_TIMEOUT_TICKS   = 8'd5;
  localparam logic [AGE_W-1:0]   CLOUD_TIMEOUT_TICKS = 8'd5;
  localparam logic [AGE_W-1:0]   AGE_MAX             = 8'hFF;
  localparam logic [CNT_W-1:0]   CNT_MAX             = 16'hFFFF;
  localparam logic [DSQ_W-1:0]   DSQ_INF             = 32'hFFFF_FFFF;
  localparam logic [SCALE_W-1:0] SCALE_ONE           = 9'd256;

  localparam logic [POS_W-1:0] FRONT_TAN_Q10           = 16'd1220;
  localparam logic [POS_W-1:0] REAR_TAN_Q10            = 16'd1220;
  localparam logic [POS_W-1:0] SIDE_COMPLEMENT_TAN_Q10 = 16'd373;
  localparam int               TAN_FRAC_BITS           = 10;

  // register reset values
  localparam logic [DSQ_W-1:0]   RST_EMG_DIST_SQ  = 32'(350 * 350);
  localparam logic [DSQ_W-1:0]   RST_SLOW_DIST_SQ = 32'(500 * 500);
  localparam logic [DSQ_W-1:0]   RST_CAUT_DIST_SQ = 32'(850 * 850);
  localparam logic [SCALE_W-1:0] RST_SLOW_SCALE   = 9'd128;
  localparam logic [SCALE_W-1:0] RST_CAUT_SCALE   = 9'd218;
  localparam logic [CNT_W-1:0]   RST_OBST_MIN     = 16'd8;
  localparam logic [CNT_W-1:0]   RST_EMG_MIN      = 16'd4;
  localparam logic [MODE_W-1:0]  RST_MODE         = 6'd63;

  typedef enum logic [1:0] {
    ACT_POINT = 2'd0,
    ACT_CLOUD = 2'd1,
    ACT_CMD   = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMG_DIST  = 3'd0,
    REG_SLOW_DIST = 3'd1,
    REG_CAUT_DIST = 3'd2,
    REG_SLOW_SCALE = 3'd3,
    REG_CAUT_SCALE = 3'd4,
    REG_OBST_MIN  = 3'd5,
    REG_EMG_MIN   = 3'd6,
    REG_MODE      = 3'd7
  } cfg_idx_t;

  // distances held squared; min point counts held with zero already mapped to one
  typedef struct packed {
    logic [DSQ_W-1:0]   emg_dist_sq;
    logic [DSQ_W-1:0]   slow_dist_sq;
    logic [DSQ_W-1:0]   caut_dist_sq;
    logic [SCALE_W-1:0] slow_scale;
    logic [SCALE_W-1:0] caut_scale;
    logic [CNT_W-1:0]   obst_min;
    logic [CNT_W-1:0]   emg_min;
    logic [MODE_W-1:0]  mode;
  } cfg_t;

  typedef struct packed {
    action_t                  action;
    logic                     point_valid;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic signed [VEL_W-1:0]  vel_turn;
  } in_item_t;

  typedef struct packed {
    action_t                 action;
    logic [NUM_SECT-1:0]     hit;
    logic [DSQ_W-1:0]        dsq;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_turn;
  } geo_item_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_turn;
    logic [SCALE_W-1:0]      fact_x;
    logic [SCALE_W-1:0]      fact_y;
    logic                    cmd_stale;
    logic                    cloud_stale;
  } lim_item_t;

endpackage

// ===== sv/lsl_point_geom.sv =====
`timescale 1ns / 1ps
// Point geometry stage: squared range and sector membership of a lidar point.
// Depends on lsl_pkg.
module lsl_point_geom
  import lsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  a_item,
  input  logic      a_valid,
  input  logic      b_take,
  output logic      b_load,
  output geo_item_t b_item_r,
  output logic      b_valid_r
);

  logic [POS_W-1:0]    ax, ay;
  logic [PROD_W-1:0]   sq_x, sq_y;
  logic [PROD_W-1:0]   ay_q10;
  logic [PROD_W-1:0]   front_lim, rear_lim, side_lim;
  logic                x_pos, x_neg, y_pos, y_neg;
  logic                is_pt;
  geo_item_t           b_item_nxt;
  logic                b_valid_nxt;

  always_comb begin
    ax = a_item.pos_x[POS_W-1] ? POS_W'(~a_item.pos_x + 1'b1) : a_item.pos_x;
    ay = a_item.pos_y[POS_W-1] ? POS_W'(~a_item.pos_y + 1'b1) : a_item.pos_y;
    sq_x      = PROD_W'(ax) * PROD_W'(ax);
    sq_y      = PROD_W'(ay) * PROD_W'(ay);
    ay_q10    = PROD_W'({ay, {TAN_FRAC_BITS{1'b0}}});
    front_lim = PROD_W'(FRONT_TAN_Q10) * PROD_W'(ax);
    rear_lim  = PROD_W'(REAR_TAN_Q10) * PROD_W'(ax);
    side_lim  = PROD_W'(SIDE_COMPLEMENT_TAN_Q10) * PROD_W'(ax);
    x_neg = a_item.pos_x[POS_W-1];
    y_neg = a_item.pos_y[POS_W-1];
    x_pos = !x_neg && (a_item.pos_x != '0);
    y_pos = !y_neg && (a_item.pos_y != '0);
    // origin point falls in no sector since none of the sign tests pass
    is_pt = (a_item.action == ACT_POINT) && a_item.point_valid;

    b_item_nxt.action   = a_item.action;
    b_item_nxt.dsq      = sq_x + sq_y;
    b_item_nxt.vel_x    = a_item.vel_x;
    b_item_nxt.vel_y    = a_item.vel_y;
    b_item_nxt.vel_turn = a_item.vel_turn;
    b_item_nxt.hit[SEC_FRONT] = is_pt && x_pos && (ay_q10 <= front_lim);
    b_item_nxt.hit[SEC_BACK]  = is_pt && x_neg && (ay_q10 <= rear_lim);
    b_item_nxt.hit[SEC_LEFT]  = is_pt && y_pos && (ay_q10 >= side_lim);
    b_item_nxt.hit[SEC_RIGHT] = is_pt && y_neg && (ay_q10 >= side_lim);
  end

  assign b_load      = !b_valid_r || b_take;
  assign b_valid_nxt = b_load ? a_valid : b_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
    if (b_load && a_valid) begin
      b_item_r <= b_item_nxt;
    end
  end

endmodule

// ===== sv/lsl_sector_track.sv =====
`timescale 1ns / 1ps
// Sector statistics, held command and ages; on a tick snapshots the limit decision.
// Depends on lsl_pkg.
module lsl_sector_track
  import lsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  geo_item_t b_item,
  input  logic      b_valid,
  output logic      b_take,
  input  logic      c_take,
  output lim_item_t c_item_r,
  output logic      c_valid_r
);

  logic [DSQ_W-1:0] min_sq_r   [NUM_SECT];
  logic [DSQ_W-1:0] min_sq_nxt [NUM_SECT];
  logic [CNT_W-1:0] cnt_r      [NUM_SECT];
  logic [CNT_W-1:0] cnt_nxt    [NUM_SECT];

  logic signed [VEL_W-1:0] held_x_r, held_y_r, held_turn_r;
  logic signed [VEL_W-1:0] held_x_nxt, held_y_nxt, held_turn_nxt;
  logic                    have_cmd_r, have_cmd_nxt;
  logic                    have_cloud_r, have_cloud_nxt;
  logic [AGE_W-1:0]        cmd_age_r, cmd_age_nxt;
  logic [AGE_W-1:0]        scan_age_r, scan_age_nxt;
  lim_item_t               c_item_nxt;
  logic                    c_valid_nxt;

  logic [NUM_SECT-1:0]     sec_en, sec_emg;
  logic [SCALE_W-1:0]      sec_fact [NUM_SECT];
  logic                    c_free;
  logic                    cmd_stale, cloud_stale;
  logic                    vx_pos, vx_neg, vy_pos, vy_neg, emg_any;
  lim_item_t               tick_res;

  assign c_free = !c_valid_r || c_take;
  assign b_take = b_valid && ((b_item.action != ACT_TICK) || c_free);

  // per-sector emergency flag and speed factor
  always_comb begin
    for (int s = 0; s < NUM_SECT; s++) begin
      sec_en[s]  = cfg.mode[MODE_EN_BASE + s];
      sec_emg[s] = sec_en[s] && (cnt_r[s] >= cfg.emg_min) &&
                   (min_sq_r[s] <= cfg.emg_dist_sq);
      if (!sec_en[s] || (cnt_r[s] < cfg.obst_min)) begin
        sec_fact[s] = SCALE_ONE;
      end else if (min_sq_r[s] <= cfg.emg_dist_sq) begin
        sec_fact[s] = '0;
      end else if (min_sq_r[s] <= cfg.slow_dist_sq) begin
        sec_fact[s] = cfg.slow_scale;
      end else if (min_sq_r[s] <= cfg.caut_dist_sq) begin
        sec_fact[s] = cfg.caut_scale;
      end else begin
        sec_fact[s] = SCALE_ONE;
      end
    end
  end

  // decision for a tick, from state as left by every earlier item
  always_comb begin
    cmd_stale   = !have_cmd_r || (cmd_age_r > CMD_TIMEOUT_TICKS);
    cloud_stale = !have_cloud_r || (scan_age_r > CLOUD_TIMEOUT_TICKS);
    vx_neg = held_x_r[VEL_W-1];
    vy_neg = held_y_r[VEL_W-1];
    vx_pos = !vx_neg && (held_x_r != '0);
    vy_pos = !vy_neg && (held_y_r != '0);
    emg_any = (vx_pos && sec_emg[SEC_FRONT]) || (vx_neg && sec_emg[SEC_BACK]) ||
              (vy_pos && sec_emg[SEC_LEFT]) || (vy_neg && sec_emg[SEC_RIGHT]);

    tick_res.cmd_stale   = cmd_stale;
    tick_res.cloud_stale = cloud_stale;
    tick_res.vel_x       = held_x_r;
    tick_res.vel_y       = held_y_r;
    tick_res.vel_turn    = held_turn_r;
    tick_res.fact_x      = SCALE_ONE;
    tick_res.fact_y      = SCALE_ONE;

    if (cmd_stale) begin
      tick_res.vel_x    = '0;
      tick_res.vel_y    = '0;
      tick_res.vel_turn = '0;
    end else if (cloud_stale) begin
      if (!cfg.mode[MODE_PASS_NOCLOUD]) begin
        tick_res.vel_x = '0;
        tick_res.vel_y = '0;
      end
    end else if (cfg.mode[MODE_ESTOP] && emg_any) begin
      tick_res.vel_x = '0;
      tick_res.vel_y = '0;
    end else begin
      tick_res.fact_x = vx_neg ? sec_fact[SEC_BACK] : sec_fact[SEC_FRONT];
      tick_res.fact_y = vy_neg ? sec_fact[SEC_RIGHT] : sec_fact[SEC_LEFT];
    end
  end

  always_comb begin
    min_sq_nxt     = min_sq_r;
    cnt_nxt        = cnt_r;
    held_x_nxt     = held_x_r;
    held_y_nxt     = held_y_r;
    held_turn_nxt  = held_turn_r;
    have_cmd_nxt   = have_cmd_r;
    have_cloud_nxt = have_cloud_r;
    cmd_age_nxt    = cmd_age_r;
    scan_age_nxt   = scan_age_r;
    c_item_nxt     = c_item_r;
    c_valid_nxt    = c_valid_r && !c_take;

    if (b_take) begin
      case (b_item.action)
        ACT_POINT: begin
          for (int s = 0; s < NUM_SECT; s++) begin
            if (b_item.hit[s] && sec_en[s]) begin
              if (cnt_r[s] != CNT_MAX) begin
                cnt_nxt[s] = cnt_r[s] + 1'b1;
              end
              if (b_item.dsq < min_sq_r[s]) begin
                min_sq_nxt[s] = b_item.dsq;
              end
            end
          end
        end
        ACT_CLOUD: begin
          for (int s = 0; s < NUM_SECT; s++) begin
            min_sq_nxt[s] = DSQ_INF;
            cnt_nxt[s]    = '0;
          end
          have_cloud_nxt = 1'b1;
          scan_age_nxt   = '0;
        end
        ACT_CMD: begin
          held_x_nxt    = b_item.vel_x;
          held_y_nxt    = b_item.vel_y;
          held_turn_nxt = b_item.vel_turn;
          have_cmd_nxt  = 1'b1;
          cmd_age_nxt   = '0;
        end
        ACT_TICK: begin
          c_item_nxt  = tick_res;
          c_valid_nxt = 1'b1;
          if (cmd_age_r != AGE_MAX) begin
            cmd_age_nxt = cmd_age_r + 1'b1;
          end
          if (scan_age_r != AGE_MAX) begin
            scan_age_nxt = scan_age_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SECT; s++) begin
        min_sq_r[s] <= DSQ_INF;
        cnt_r[s]    <= '0;
      end
      held_x_r     <= '0;
      held_y_r     <= '0;
      held_turn_r  <= '0;
      have_cmd_r   <= 1'b0;
      have_cloud_r <= 1'b0;
      cmd_age_r    <= '0;
      scan_age_r   <= '0;
      c_valid_r    <= 1'b0;
    end else begin
      min_sq_r     <= min_sq_nxt;
      cnt_r        <= cnt_nxt;
      held_x_r     <= held_x_nxt;
      held_y_r     <= held_y_nxt;
      held_turn_r  <= held_turn_nxt;
      have_cmd_r   <= have_cmd_nxt;
      have_cloud_r <= have_cloud_nxt;
      cmd_age_r    <= cmd_age_nxt;
      scan_age_r   <= scan_age_nxt;
      c_valid_r    <= c_valid_nxt;
    end
    c_item_r <= c_item_nxt;
  end

endmodule

// ===== sv/lsl_speed_scale.sv =====
`timescale 1ns / 1ps
// Q1.8 scaling with saturation of each linear axis, into the result register.
// Depends on lsl_pkg.
module lsl_speed_scale
  import lsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lim_item_t         c_item,
  input  logic              c_valid,
  output logic              c_take,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [47:0]       out_tdata,
  output logic [1:0]        out_tuser
);

  localparam int MAG_PROD_W = VEL_W + SCALE_W;
  localparam int RES_W      = MAG_PROD_W - 8;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VEL_W-1:0] vx_r, vy_r, vt_r;
  logic                    cmd_stale_r, cloud_stale_r;
  logic                    c_move;
  logic signed [VEL_W-1:0] vx_scl, vy_scl;

  // |v|*f >> 8 toward zero, sign restored, clamped to 16-bit signed
  function automatic logic signed [VEL_W-1:0] scale_vel(
    input logic signed [VEL_W-1:0] v,
    input logic [SCALE_W-1:0]      f
  );
    logic [VEL_W-1:0]      mag;
    logic [MAG_PROD_W-1:0] prod;
    logic [RES_W-1:0]      r;
    logic signed [VEL_W-1:0] res;
    mag  = v[VEL_W-1] ? VEL_W'(~v + 1'b1) : v;
    prod = MAG_PROD_W'(mag) * MAG_PROD_W'(f);
    r    = prod[MAG_PROD_W-1:8];
    if (v[VEL_W-1]) begin
      if (r > RES_W'(32768)) begin
        res = 16'sh8000;
      end else begin
        res = VEL_W'(~r + 1'b1);
      end
    end else begin
      if (r > RES_W'(32767)) begin
        res = 16'sh7FFF;
      end else begin
        res = VEL_W'(r);
      end
    end
    return res;
  endfunction

  assign c_move        = !out_valid_r || out_tready;
  assign c_take        = c_valid && c_move;
  assign out_valid_nxt = c_move ? c_valid : out_valid_r;

  always_comb begin
    vx_scl = scale_vel(c_item.vel_x, c_item.fact_x);
    vy_scl = scale_vel(c_item.vel_y, c_item.fact_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (c_take) begin
      vx_r          <= vx_scl;
      vy_r          <= vy_scl;
      vt_r          <= c_item.vel_turn;
      cmd_stale_r   <= c_item.cmd_stale;
      cloud_stale_r <= c_item.cloud_stale;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {vt_r, vy_r, vx_r};
  assign out_tuser  = {cloud_stale_r, cmd_stale_r};

endmodule

// ===== sv/lidar_sector_speed_limiter.sv =====
`timescale 1ns / 1ps
// Lidar sector speed limiter, top level: input register, configuration registers,
// point geometry, sector tracking and speed scaling. Depends on lsl_pkg and submodules.
// A tick passes the input register, geometry register and decision register into the result register.
// Throughput: one transaction per cycle on every action; only ticks produce results.
// The input side stalls only when a tick waits for the result register and the two
// buffered ticks ahead of it are still held by out_tready.
// Reset (rst_n low, synchronous): registers to defaults, sectors empty, no command, no cloud.
module lidar_sector_speed_limiter
  import lsl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [79:0]           in_tdata,   // pos_x, pos_y, vel_x, vel_y, vel_turn
  input  logic [2:0]            in_tuser,   // action[1:0], point_valid
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // out_vel_x, out_vel_y, out_turn
  output logic [1:0]            out_tuser,  // cmd_stale, cloud_stale
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg_r, cfg_nxt;
  logic [DSQ_W-1:0] wr_sq;
  logic [CNT_W-1:0] wr_min;

  in_item_t  a_item_r, a_item_nxt;
  logic      a_valid_r, a_valid_nxt;
  logic      a_load;
  logic      b_load, b_take, b_valid;
  geo_item_t b_item;
  lim_item_t c_item;
  logic      c_valid, c_take;

  assign cfg_ready = 1'b1;

  always_comb begin
    wr_sq   = DSQ_W'(cfg_data) * DSQ_W'(cfg_data);
    wr_min  = (cfg_data == '0) ? CNT_W'(1) : cfg_data;
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_EMG_DIST:   cfg_nxt.emg_dist_sq  = wr_sq;
        REG_SLOW_DIST:  cfg_nxt.slow_dist_sq = wr_sq;
        REG_CAUT_DIST:  cfg_nxt.caut_dist_sq = wr_sq;
        REG_SLOW_SCALE: cfg_nxt.slow_scale   = cfg_data[SCALE_W-1:0];
        REG_CAUT_SCALE: cfg_nxt.caut_scale   = cfg_data[SCALE_W-1:0];
        REG_OBST_MIN:   cfg_nxt.obst_min     = wr_min;
        REG_EMG_MIN:    cfg_nxt.emg_min      = wr_min;
        REG_MODE:       cfg_nxt.mode         = cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register stage
  always_comb begin
    a_item_nxt.action      = action_t'(in_tuser[1:0]);
    a_item_nxt.point_valid = in_tuser[2];
    a_item_nxt.pos_x       = in_tdata[15:0];
    a_item_nxt.pos_y       = in_tdata[31:16];
    a_item_nxt.vel_x       = in_tdata[47:32];
    a_item_nxt.vel_y       = in_tdata[63:48];
    a_item_nxt.vel_turn    = in_tdata[79:64];
  end

  assign a_load      = !a_valid_r || b_load;
  assign in_tready   = a_load;
  assign a_valid_nxt = a_load ? in_tvalid : a_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.emg_dist_sq  <= RST_EMG_DIST_SQ;
      cfg_r.slow_dist_sq <= RST_SLOW_DIST_SQ;
      cfg_r.caut_dist_sq <= RST_CAUT_DIST_SQ;
      cfg_r.slow_scale   <= RST_SLOW_SCALE;
      cfg_r.caut_scale   <= RST_CAUT_SCALE;
      cfg_r.obst_min     <= RST_OBST_MIN;
      cfg_r.emg_min      <= RST_EMG_MIN;
      cfg_r.mode         <= RST_MODE;
      a_valid_r          <= 1'b0;
    end else begin
      cfg_r     <= cfg_nxt;
      a_valid_r <= a_valid_nxt;
    end
    if (a_load && in_tvalid) begin
      a_item_r <= a_item_nxt;
    end
  end

  lsl_point_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_item    (a_item_r),
    .a_valid   (a_valid_r),
    .b_take    (b_take),
    .b_load    (b_load),
    .b_item_r  (b_item),
    .b_valid_r (b_valid)
  );

  lsl_sector_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .b_item    (b_item),
    .b_valid   (b_valid),
    .b_take    (b_take),
    .c_take    (c_take),
    .c_item_r  (c_item),
    .c_valid_r (c_valid)
  );

  lsl_speed_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .c_item     (c_item),
    .c_valid    (c_valid),
    .c_take     (c_take),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
